// File: design/u8u16_pkg.sv
// u8u16_pkg: types and constants shared by the UTF-8 to UTF-16 transcoder.
// No dependencies; every design file refers to it by scoped names.
package u8u16_pkg;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_LEAD   = 3'd1,
      ST_BAD_CONT   = 3'd2,
      ST_BAD_SCALAR = 3'd3,
      ST_TRUNCATED  = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        unit_valid;
      status_type  status;
      logic        string_done;
      logic        last;
   } rsp_type;

   // Output queue geometry: room for two full bursts of two results
   localparam int FIFO_AW    = 2;
   localparam int FIFO_DEPTH = 1 << FIFO_AW;

   // Decoder to queue: number of results made by this byte and the results
   typedef struct packed {
      logic [1:0] count;
      rsp_type    res0;
      rsp_type    res1;
   } dec_out_type;

   // Queue status back to the top level
   typedef struct packed {
      logic             has_room;
      logic [FIFO_AW:0] level;
   } fifo_stat_type;

   localparam logic [20:0] MIN_LEN2     = 21'h000080;
   localparam logic [20:0] MIN_LEN3     = 21'h000800;
   localparam logic [20:0] MIN_LEN4     = 21'h010000;
   localparam logic [20:0] SUPP_BASE    = 21'h010000;
   localparam logic [20:0] MAX_SCALAR   = 21'h10FFFF;
   localparam logic [20:0] SURR_FIRST   = 21'h00D800;
   localparam logic [20:0] SURR_LAST    = 21'h00DFFF;
   localparam logic [15:0] HIGH_SURR    = 16'hD800;
   localparam logic [15:0] LOW_SURR     = 16'hDC00;

endpackage

// File: design/u8u16_decoder.sv
// u8u16_decoder: UTF-8 sequence state and per-byte decode into up to two results.
// Depends on u8u16_pkg.
module u8u16_decoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  u8u16_pkg::req_type    req,
   output u8u16_pkg::dec_out_type dec_out
);

   logic [20:0] acc_ff, acc_in;
   logic [1:0]  rem_ff, rem_in;
   logic [2:0]  len_ff, len_in;
   logic        badc_ff, badc_in;
   logic        disc_ff, disc_in;

   logic                  eos;
   logic [7:0]            b;
   logic                  emit_err;
   u8u16_pkg::status_type err_st;
   logic                  emit_sc;
   logic [20:0]           sc_cp;
   logic [20:0]           shifted;
   logic                  cont_bad;
   logic                  overlong;
   logic [20:0]           off;

   always_comb begin
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      len_in   = len_ff;
      badc_in  = badc_ff;
      disc_in  = disc_ff;
      eos      = req.end_of_string;
      b        = req.data_byte;
      emit_err = 1'b0;
      err_st   = u8u16_pkg::ST_OK;
      emit_sc  = 1'b0;
      sc_cp    = {13'd0, b};
      shifted  = {acc_ff[14:0], b[5:0]};
      cont_bad = badc_ff | (b[7:6] != 2'b10);
      overlong = ((len_ff == 3'd2) && (shifted < u8u16_pkg::MIN_LEN2)) ||
                 ((len_ff == 3'd3) && (shifted < u8u16_pkg::MIN_LEN3)) ||
                 ((len_ff == 3'd4) && (shifted < u8u16_pkg::MIN_LEN4));
      if (fire) begin
         if (disc_ff) begin
            if (eos) begin
               disc_in = 1'b0;
            end
         end else if (rem_ff == 2'd0) begin
            if (!b[7]) begin
               emit_sc = 1'b1;
            end else begin
               badc_in = 1'b0;
               if (b[7:5] == 3'b110) begin
                  acc_in = {16'd0, b[4:0]};
                  rem_in = 2'd1;
                  len_in = 3'd2;
               end else if (b[7:4] == 4'b1110) begin
                  acc_in = {17'd0, b[3:0]};
                  rem_in = 2'd2;
                  len_in = 3'd3;
               end else if (b[7:3] == 5'b11110) begin
                  acc_in = {18'd0, b[2:0]};
                  rem_in = 2'd3;
                  len_in = 3'd4;
               end else begin
                  emit_err = 1'b1;
                  err_st   = u8u16_pkg::ST_BAD_LEAD;
               end
               // lead byte that also ends the string
               if (!emit_err && eos) begin
                  emit_err = 1'b1;
                  err_st   = u8u16_pkg::ST_TRUNCATED;
               end
            end
         end else if (rem_ff == 2'd1) begin
            acc_in  = '0;
            rem_in  = 2'd0;
            len_in  = 3'd0;
            badc_in = 1'b0;
            if (cont_bad) begin
               emit_err = 1'b1;
               err_st   = u8u16_pkg::ST_BAD_CONT;
            end else if (overlong || (shifted > u8u16_pkg::MAX_SCALAR) ||
                         ((shifted >= u8u16_pkg::SURR_FIRST) &&
                          (shifted <= u8u16_pkg::SURR_LAST))) begin
               emit_err = 1'b1;
               err_st   = u8u16_pkg::ST_BAD_SCALAR;
            end else begin
               emit_sc = 1'b1;
               sc_cp   = shifted;
            end
         end else if (eos) begin
            emit_err = 1'b1;
            err_st   = u8u16_pkg::ST_TRUNCATED;
         end else begin
            acc_in  = shifted;
            rem_in  = rem_ff - 2'd1;
            badc_in = cont_bad;
         end
         if (emit_err) begin
            acc_in  = '0;
            rem_in  = 2'd0;
            len_in  = 3'd0;
            badc_in = 1'b0;
            disc_in = !eos;
         end
      end
   end

   // Result formation
   always_comb begin
      off     = sc_cp - u8u16_pkg::SUPP_BASE;
      dec_out = '0;
      if (emit_err) begin
         dec_out.count            = 2'd1;
         dec_out.res0.status      = err_st;
         dec_out.res0.string_done = 1'b1;
         dec_out.res0.last        = 1'b1;
      end else if (emit_sc) begin
         if (sc_cp[20:16] == 5'd0) begin
            dec_out.count            = 2'd1;
            dec_out.res0.code_unit   = sc_cp[15:0];
            dec_out.res0.unit_valid  = 1'b1;
            dec_out.res0.string_done = eos;
            dec_out.res0.last        = 1'b1;
         end else begin
            dec_out.count            = 2'd2;
            dec_out.res0.code_unit   = u8u16_pkg::HIGH_SURR | {6'd0, off[19:10]};
            dec_out.res0.unit_valid  = 1'b1;
            dec_out.res1.code_unit   = u8u16_pkg::LOW_SURR | {6'd0, off[9:0]};
            dec_out.res1.unit_valid  = 1'b1;
            dec_out.res1.string_done = eos;
            dec_out.res1.last        = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         rem_ff  <= '0;
         len_ff  <= '0;
         badc_ff <= 1'b0;
         disc_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         rem_ff  <= rem_in;
         len_ff  <= len_in;
         badc_ff <= badc_in;
         disc_ff <= disc_in;
      end
   end

endmodule

// File: design/u8u16_rsp_fifo.sv
// u8u16_rsp_fifo: result queue taking up to two items per cycle, giving one.
// Depends on u8u16_pkg.
module u8u16_rsp_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  u8u16_pkg::dec_out_type    push,
   input  logic                      pop,
   output logic                      rsp_valid,
   output u8u16_pkg::rsp_type        rsp_payload,
   output u8u16_pkg::fifo_stat_type  stat
);

   localparam int LW = u8u16_pkg::FIFO_AW + 1;

   u8u16_pkg::rsp_type entry_ff [u8u16_pkg::FIFO_DEPTH];

   logic [u8u16_pkg::FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [u8u16_pkg::FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]                 level_ff, level_in;
   logic [u8u16_pkg::FIFO_AW-1:0] wr_next;

   assign wr_next     = wr_ptr_ff + u8u16_pkg::FIFO_AW'(1);
   assign rsp_valid   = (level_ff != '0);
   assign rsp_payload = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + u8u16_pkg::FIFO_AW'(push.count);
      rd_ptr_in = rd_ptr_ff + u8u16_pkg::FIFO_AW'(pop);
      level_in  = level_ff + LW'(push.count) - LW'(pop);
   end

   // room for a full burst of two
   assign stat.has_room = (level_ff <= LW'(u8u16_pkg::FIFO_DEPTH - 2));
   assign stat.level    = level_ff;

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

// File: design/utf8_to_utf16_transcoder_unit.sv
// UTF-8 to UTF-16 transcoder, top level. Uses u8u16_pkg, u8u16_decoder, u8u16_rsp_fifo.
// A byte's results are registered into the result queue, behind any older results.
// Throughput: one byte per cycle while req_ready is high; a pair gives two results.
// The 4-entry result queue holds req_ready low when fewer than 2 slots are free.
// Reset (synchronous, active high) clears sequence state, discard flag and queue.
module utf8_to_utf16_transcoder_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  u8u16_pkg::req_type  req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output u8u16_pkg::rsp_type  rsp_payload
);

   logic                     req_fire;
   logic                     rsp_fire;
   u8u16_pkg::dec_out_type   dec_out;
   u8u16_pkg::fifo_stat_type fifo_stat;

   // A byte is taken only when the queue can absorb a worst-case pair
   assign req_ready = fifo_stat.has_room;
   assign req_fire  = req_valid & req_ready;
   assign rsp_fire  = rsp_valid & rsp_ready;

   // Decode: sequence state lives here; results come out in the accept cycle
   u8u16_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .fire    (req_fire),
      .req     (req_payload),
      .dec_out (dec_out)
   );

   // Result register stage: small queue decouples bursts from the consumer
   u8u16_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (dec_out),
      .pop         (rsp_fire),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .stat        (fifo_stat)
   );

   // Results appear only for an accepted byte
   assert property (@(posedge clock) disable iff (reset)
      (dec_out.count != 2'd0) |-> req_fire)
      else $error("decoder produced results without an accepted item");

   // Queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      fifo_stat.level <= (u8u16_pkg::FIFO_AW + 1)'(u8u16_pkg::FIFO_DEPTH))
      else $error("result queue overflow");

   // A pair pushed with no pop raises the level by two
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (dec_out.count == 2'd2) && !rsp_fire) |=>
      (fifo_stat.level == $past(fifo_stat.level) + (u8u16_pkg::FIFO_AW + 1)'(2)))
      else $error("surrogate pair not fully queued");

   // The second result of a pair carries the last flag; the first does not
   assert property (@(posedge clock) disable iff (reset)
      (dec_out.count == 2'd2) |-> (dec_out.res1.last && !dec_out.res0.last))
      else $error("last flag misplaced on pair");

endmodule

// File: bench/u8u16_stream_checker.sv
// u8u16_stream_checker: watches both channels of the transcoder, predicts each
// result from the accepted bytes and compares. Depends on u8u16_pkg.
module u8u16_stream_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  u8u16_pkg::req_type  req_payload,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  u8u16_pkg::rsp_type  rsp_payload,
   output int                  error_count,
   output int                  units_pending
);

   // predicted decoder state
   logic [20:0] scalar_bits;
   logic [1:0]  cont_left;
   logic [2:0]  seq_bytes;
   logic        cont_broken;
   logic        dropping;

   u8u16_pkg::rsp_type expected_units[$];
   int                 mismatches;

   initial begin
      error_count = 0;
      units_pending = 0;
      mismatches = 0;
   end

   function automatic void clear_sequence();
      scalar_bits = '0;
      cont_left = '0;
      seq_bytes = '0;
      cont_broken = 1'b0;
   endfunction

   function automatic void add_unit(input logic [15:0] unit, input logic has_unit,
                                    input u8u16_pkg::status_type st, input logic done);
      u8u16_pkg::rsp_type r;
      r.code_unit = unit;
      r.unit_valid = has_unit;
      r.status = st;
      r.string_done = done;
      r.last = 1'b0;
      expected_units = {expected_units, r};
   endfunction

   function automatic void add_error(input u8u16_pkg::status_type st, input logic eos);
      clear_sequence();
      dropping = !eos;
      add_unit(16'h0000, 1'b0, st, 1'b1);
   endfunction

   function automatic void add_scalar(input logic [20:0] cp, input logic eos);
      logic [20:0] off;
      if (cp < u8u16_pkg::SUPP_BASE) begin
         add_unit(cp[15:0], 1'b1, u8u16_pkg::ST_OK, eos);
      end else begin
         off = cp - u8u16_pkg::SUPP_BASE;
         add_unit(u8u16_pkg::HIGH_SURR + {6'd0, off[19:10]}, 1'b1, u8u16_pkg::ST_OK, 1'b0);
         add_unit(u8u16_pkg::LOW_SURR + {6'd0, off[9:0]}, 1'b1, u8u16_pkg::ST_OK, eos);
      end
   endfunction

   // one accepted byte -> zero, one or two expected results
   function automatic void decode_utf8_byte(input u8u16_pkg::req_type item);
      logic [7:0]         b;
      logic               eos;
      int                 first;
      logic [20:0]        cp;
      u8u16_pkg::rsp_type tail;
      b = item.data_byte;
      eos = item.end_of_string;
      first = expected_units.size();
      if (dropping) begin
         if (eos) dropping = 1'b0;
         return;
      end
      if (cont_left == 2'd0) begin
         if (!b[7]) begin
            add_scalar({13'd0, b}, eos);
         end else begin
            cont_broken = 1'b0;
            if (b[7:5] == 3'b110) begin
               scalar_bits = {16'd0, b[4:0]};
               cont_left = 2'd1;
               seq_bytes = 3'd2;
            end else if (b[7:4] == 4'b1110) begin
               scalar_bits = {17'd0, b[3:0]};
               cont_left = 2'd2;
               seq_bytes = 3'd3;
            end else if (b[7:3] == 5'b11110) begin
               scalar_bits = {18'd0, b[2:0]};
               cont_left = 2'd3;
               seq_bytes = 3'd4;
            end else begin
               add_error(u8u16_pkg::ST_BAD_LEAD, eos);
            end
            if (expected_units.size() == first && eos)
               add_error(u8u16_pkg::ST_TRUNCATED, eos);
         end
      end else begin
         if (b[7:6] != 2'b10) cont_broken = 1'b1;
         scalar_bits = {scalar_bits[14:0], b[5:0]};
         cont_left = cont_left - 2'd1;
         if (cont_left == 2'd0) begin
            cp = scalar_bits;
            if (cont_broken) begin
               add_error(u8u16_pkg::ST_BAD_CONT, eos);
            end else if ((seq_bytes == 3'd2 && cp < u8u16_pkg::MIN_LEN2) ||
                         (seq_bytes == 3'd3 && cp < u8u16_pkg::MIN_LEN3) ||
                         (seq_bytes == 3'd4 && cp < u8u16_pkg::MIN_LEN4) ||
                         cp > u8u16_pkg::MAX_SCALAR ||
                         (cp >= u8u16_pkg::SURR_FIRST && cp <= u8u16_pkg::SURR_LAST)) begin
               add_error(u8u16_pkg::ST_BAD_SCALAR, eos);
            end else begin
               clear_sequence();
               add_scalar(cp, eos);
            end
         end else if (eos) begin
            add_error(u8u16_pkg::ST_TRUNCATED, eos);
         end
      end
      if (expected_units.size() > first) begin
         tail = expected_units.pop_back();
         tail.last = 1'b1;
         expected_units = {expected_units, tail};
      end
   endfunction

   always @(posedge clock) begin
      u8u16_pkg::rsp_type want;
      if (reset) begin
         clear_sequence();
         dropping = 1'b0;
         expected_units.delete();
      end else begin
         // results first: a result never comes from a byte taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_units.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: unit %h valid %b status %0d done %b last %b",
                           rsp_payload.code_unit, rsp_payload.unit_valid,
                           rsp_payload.status, rsp_payload.string_done, rsp_payload.last);
            end else begin
               want = expected_units.pop_front();
               if (rsp_payload.code_unit !== want.code_unit ||
                   rsp_payload.unit_valid !== want.unit_valid ||
                   rsp_payload.status !== want.status ||
                   rsp_payload.string_done !== want.string_done ||
                   rsp_payload.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: exp unit %h valid %b status %0d done %b last %b,",
                               " got unit %h valid %b status %0d done %b last %b"},
                              want.code_unit, want.unit_valid, want.status,
                              want.string_done, want.last,
                              rsp_payload.code_unit, rsp_payload.unit_valid,
                              rsp_payload.status, rsp_payload.string_done, rsp_payload.last);
               end
            end
         end
         if (req_valid && req_ready) decode_utf8_byte(req_payload);
      end
      error_count <= mismatches;
      units_pending <= expected_units.size();
   end

endmodule

// File: bench/tb_utf8_to_utf16_transcoder_unit.sv
// tb_utf8_to_utf16_transcoder_unit: drives byte strings into the transcoder,
// stalls the result side, and reports the verdict from u8u16_stream_checker.
// Depends on u8u16_pkg, utf8_to_utf16_transcoder_unit and the checker.
module tb_utf8_to_utf16_transcoder_unit;

   localparam int WATCHDOG_LIMIT = 1000;   // cycles with no item moved on either side
   localparam int DIRECTED_ITEMS = 27;
   localparam int PHASE_ITEMS    = 100;
   localparam int PHASES         = 7;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   u8u16_pkg::req_type req_payload = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   u8u16_pkg::rsp_type rsp_payload;

   int error_count;
   int units_pending;

   // idle controls: percent chance per item / per cycle to start a burst
   int gap_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;
   int items_sent = 0;
   int idle_cycles = 0;

   logic [7:0] string_bytes[$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   utf8_to_utf16_transcoder_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   u8u16_stream_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .error_count   (error_count),
      .units_pending (units_pending)
   );

   // Result side: ready drops for bursts of random length.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: any item moving on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // One byte. Called at a rising edge; returns at the edge that takes the item.
   // An idle gap, if any, comes before the byte so valid never falls mid-item.
   task automatic send_byte(input logic [7:0] b, input logic eos);
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_payload <= '{data_byte: b, end_of_string: eos};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Sends a byte run; close marks the final byte as the string's end.
   task automatic send_string(input logic [7:0] seq[$], input logic close);
      for (int i = 0; i < seq.size(); i++)
         send_byte(seq[i], close && (i == seq.size() - 1));
   endtask

   // Hold the sender until every predicted result has been taken.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (units_pending != 0);
   endtask

   // Encode cp in len bytes; a len longer than needed gives an overlong form.
   function automatic void push_scalar(input logic [20:0] cp, input int len);
      case (len)
         1: string_bytes = {string_bytes, {1'b0, cp[6:0]}};
         2: begin
            string_bytes = {string_bytes, {3'b110, cp[10:6]}};
            string_bytes = {string_bytes, {2'b10, cp[5:0]}};
         end
         3: begin
            string_bytes = {string_bytes, {4'b1110, cp[15:12]}};
            string_bytes = {string_bytes, {2'b10, cp[11:6]}};
            string_bytes = {string_bytes, {2'b10, cp[5:0]}};
         end
         default: begin
            string_bytes = {string_bytes, {5'b11110, cp[20:18]}};
            string_bytes = {string_bytes, {2'b10, cp[17:12]}};
            string_bytes = {string_bytes, {2'b10, cp[11:6]}};
            string_bytes = {string_bytes, {2'b10, cp[5:0]}};
         end
      endcase
   endfunction

   initial begin
      int          pick;
      int          len;
      int          fault;
      int          spot;
      logic [20:0] cp;
      int          gap_plan[PHASES]   = '{25, 0, 50, 10, 40, 0, 0};
      int          stall_plan[PHASES] = '{25, 40, 0, 10, 50, 0, 0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, every status, and the odd paths of the decoder.
      send_string('{8'h00}, 1'b1);                           // smallest scalar, ends string
      send_string('{8'h7F}, 1'b0);                           // largest one-byte scalar
      send_string('{8'hC2, 8'h80}, 1'b0);                    // smallest two-byte scalar
      send_string('{8'hF4, 8'h8F, 8'hBF, 8'hBF}, 1'b1);      // U+10FFFF, surrogate pair
      send_string('{8'hFF, 8'h41}, 1'b1);                    // bad lead, rest dropped
      send_string('{8'h80}, 1'b1);                           // stray continuation at end
      send_string('{8'hC0, 8'h80, 8'h41}, 1'b1);             // overlong, then dropped byte
      send_string('{8'hED, 8'hA0, 8'h80}, 1'b1);             // encoded surrogate
      send_string('{8'hF5, 8'h80, 8'h80, 8'h80}, 1'b1);      // above U+10FFFF
      send_string('{8'hE2, 8'h41, 8'h82}, 1'b1);             // broken continuation
      send_string('{8'hF0}, 1'b1);                           // string ends on a lead
      send_string('{8'hE2, 8'h41}, 1'b1);                    // truncation wins over bad cont
      drain();

      // Random strings, phase by phase; the last phases run without idling.
      for (int phase = 0; phase < PHASES; phase++) begin
         gap_pct = gap_plan[phase];
         stall_pct = stall_plan[phase];
         drain();
         while (items_sent < DIRECTED_ITEMS + (phase + 1) * PHASE_ITEMS) begin
            string_bytes.delete();
            if ($urandom_range(0, 99) < 15) begin
               // raw noise
               repeat ($urandom_range(1, 8))
                  string_bytes = {string_bytes, 8'($urandom_range(0, 255))};
            end else begin
               repeat ($urandom_range(1, 5)) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 25) begin
                     push_scalar(21'($urandom_range(0, 'h7F)), 1);
                  end else if (pick < 45) begin
                     push_scalar(21'($urandom_range('h80, 'h7FF)), 2);
                  end else if (pick < 70) begin
                     cp = 21'($urandom_range('h800, 'hFFFF));
                     if (cp >= u8u16_pkg::SURR_FIRST && cp <= u8u16_pkg::SURR_LAST)
                        cp = cp - 21'h1000;
                     push_scalar(cp, 3);
                  end else if (pick < 92) begin
                     push_scalar(21'($urandom_range('h10000, 'h10FFFF)), 4);
                  end else if (pick < 95) begin
                     // overlong: value fits a shorter form
                     len = $urandom_range(2, 4);
                     cp = 21'($urandom_range(0, len == 2 ? 'h7F : len == 3 ? 'h7FF : 'hFFFF));
                     push_scalar(cp, len);
                  end else if (pick < 97) begin
                     push_scalar(21'($urandom_range('hD800, 'hDFFF)), 3);
                  end else begin
                     push_scalar(21'($urandom_range('h110000, 'h1FFFFF)), 4);
                  end
               end
               // occasional damage to an otherwise clean string
               fault = $urandom_range(0, 99);
               spot = $urandom_range(0, string_bytes.size() - 1);
               if (fault < 6) begin
                  string_bytes[spot] = 8'($urandom_range(0, 255));
               end else if (fault < 12 && string_bytes.size() > 1) begin
                  repeat ($urandom_range(1, string_bytes.size() > 3 ? 3 : string_bytes.size() - 1))
                     void'(string_bytes.pop_back());
               end else if (fault < 16) begin
                  string_bytes.insert(spot, 8'($urandom_range('h80, 'hFF)));
               end
            end
            send_string(string_bytes, 1'b1);
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (units_pending != 0);
      repeat (16) @(posedge clock);

      if (error_count == 0 && units_pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: files.f
design/u8u16_pkg.sv
design/u8u16_decoder.sv
design/u8u16_rsp_fifo.sv
design/utf8_to_utf16_transcoder_unit.sv
bench/u8u16_stream_checker.sv
bench/tb_utf8_to_utf16_transcoder_unit.sv
